>>> src/swmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_pkg: shared types for the sliding window min/max block
// Control bundle broadcast to every queue cell, and the cell load select.
// ----------------------------------------------------------------------------
package swmm_pkg;

  // Broadcast control for one clock
  typedef struct packed {
    logic step;     // item accepted this cycle
    logic restart;  // item starts a new sequence: queues empty before push
    logic flush;    // register write: queues empty, no push
  } ctl_t;

  // Next contents of a queue cell
  typedef enum logic [2:0] {
    SEL_COPY  = 3'b001,  // surviving entry from own or right-hand cell
    SEL_LOAD  = 3'b010,  // new item lands here
    SEL_EMPTY = 3'b100   // cell falls out of the occupied run
  } sel_e;

endpackage

>>> src/sliding_window_min_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_min_max: running minimum and maximum over a sample window
// Two cell-chain monotonic queues with a registered result stage.
// ----------------------------------------------------------------------------
// Usage: write the window length (1..WINDOW_MAX; 0 acts as 1, larger values
// as WINDOW_MAX) through the cfg port while the block is idle; the write also
// empties both queues and restarts the count. Each accepted item enters both
// queues together, so one item per cycle is sustained; the result for an item
// appears on the output in the cycle after acceptance. Throughput is set by
// the cell rows: every cell compares its entry with the new sample in
// parallel and takes data from itself or its right neighbor, so a push plus a
// head expiry completes together. No result is produced until a full
// window of items of the current sequence has arrived; first_sample_i starts
// a new sequence. The input stalls only while a finished result is held.
// ----------------------------------------------------------------------------
module sliding_window_min_max #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic        [6:0]              cfg_data_i,
  // item in
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           first_sample_i,
  // result out
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] window_min_o,
  output logic signed [SAMPLE_WIDTH-1:0] window_max_o
);
  import swmm_pkg::*;

  // counts and ages need to hold the window length itself
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  logic [6:0]                     wsize_q;
  logic [CNT_W-1:0]               win;
  logic [CNT_W-1:0]               seen_q, seen_d;
  logic                           cfg_acc, in_acc, out_acc, result;
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] min_q, max_q, min_d, max_d;
  ctl_t                           ctl;

  // handshakes; a held result only blocks input while it is stalled
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;

  // effective window: clamp register to 1..WINDOW_MAX
  always_comb begin
    if (wsize_q == 7'd0) begin
      win = CNT_W'(1);
    end else if (CMP_W'(wsize_q) > CMP_W'(WINDOW_MAX)) begin
      win = CNT_W'(WINDOW_MAX);
    end else begin
      win = CNT_W'(wsize_q);
    end
  end

  assign ctl.step    = in_acc;
  assign ctl.restart = first_sample_i;
  assign ctl.flush   = cfg_acc;

  // item count of current sequence, saturating at the window
  always_comb begin
    if (first_sample_i) begin
      seen_d = CNT_W'(1);
    end else if (seen_q < win) begin
      seen_d = seen_q + CNT_W'(1);
    end else begin
      seen_d = seen_q;
    end
  end
  assign result = (seen_d >= win);

  swmm_chain #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .DEPTH       (WINDOW_MAX),
    .AGE_W       (CNT_W),
    .KEEP_MAX    (1'b0)
  ) u_min_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .win_i   (win),
    .key_i   (sample_i),
    .head_d_o(min_d)
  );

  swmm_chain #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .DEPTH       (WINDOW_MAX),
    .AGE_W       (CNT_W),
    .KEEP_MAX    (1'b1)
  ) u_max_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .win_i   (win),
    .key_i   (sample_i),
    .head_d_o(max_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q     <= 7'd3;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_acc) begin
        wsize_q <= cfg_data_i;
        seen_q  <= '0;
      end else if (in_acc) begin
        seen_q <= seen_d;
      end
      if (in_acc) begin
        out_valid_q <= result;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (in_acc && result) begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_min_o = min_q;
  assign window_max_o = max_q;

  // a restarting item only yields a result for a one-item window
  a_restart_nores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && first_sample_i && (win != CNT_W'(1))) |=> !out_valid_o)
    else $error("sliding_window_min_max: result right after restart");

  // minimum never exceeds maximum
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (window_min_o <= window_max_o))
    else $error("sliding_window_min_max: min above max");

  // count never passes the window
  a_seen_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= win)
    else $error("sliding_window_min_max: item count past window");

endmodule

>>> src/swmm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_cell: one entry of a monotonic queue
// Holds a value, its age and a valid bit; shifts toward the head on expiry.
// ----------------------------------------------------------------------------
module swmm_cell #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int AGE_W        = 7,
  parameter bit KEEP_MAX     = 1'b0,
  parameter bit IS_HEAD      = 1'b0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swmm_pkg::ctl_t                 ctl_i,
  input  logic                           shift_i,
  input  logic signed [SAMPLE_WIDTH-1:0] key_i,
  input  logic                           kept_prev_i,
  input  logic                           kept_next_i,
  input  logic signed [SAMPLE_WIDTH-1:0] nxt_val_i,
  input  logic        [AGE_W-1:0]        nxt_age_i,
  output logic                           kept_o,
  output logic signed [SAMPLE_WIDTH-1:0] val_o,
  output logic        [AGE_W-1:0]        age_o,
  output logic                           valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] val_d_o
);
  import swmm_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] val_q, val_d;
  logic        [AGE_W-1:0]        age_q, age_d;
  logic                           valid_q, valid_d;
  logic                           dom, src_kept, left_kept;
  sel_e                           sel;

  // entry is dominated by the new key (ties go to the newer item)
  assign dom = KEEP_MAX ? (val_q <= key_i) : (val_q >= key_i);

  assign kept_o = valid_q && !dom && !(IS_HEAD && shift_i) && !ctl_i.restart;

  always_comb begin
    src_kept  = shift_i ? kept_next_i : kept_o;
    left_kept = IS_HEAD ? 1'b1 : (shift_i ? kept_o : kept_prev_i);
    if (src_kept) begin
      sel = SEL_COPY;
    end else if (left_kept) begin
      sel = SEL_LOAD;
    end else begin
      sel = SEL_EMPTY;
    end
  end

  always_comb begin
    val_d   = val_q;
    age_d   = age_q;
    valid_d = valid_q;
    unique case (sel)
      SEL_COPY: begin
        val_d   = shift_i ? nxt_val_i : val_q;
        age_d   = (shift_i ? nxt_age_i : age_q) + AGE_W'(1);
        valid_d = 1'b1;
      end
      SEL_LOAD: begin
        val_d   = key_i;
        age_d   = '0;
        valid_d = 1'b1;
      end
      SEL_EMPTY: begin
        age_d   = '0;
        valid_d = 1'b0;
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else if (ctl_i.flush) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else if (ctl_i.step) begin
      valid_q <= valid_d;
      age_q   <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step && !ctl_i.flush) begin
      val_q <= val_d;
    end
  end

  assign val_o   = val_q;
  assign age_o   = age_q;
  assign valid_o = valid_q;
  assign val_d_o = val_d;

endmodule

>>> src/swmm_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmm_chain: monotonic queue built as a row of cells
// Head at cell 0; expiry of the head shifts the row by one place.
// ----------------------------------------------------------------------------
module swmm_chain #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int DEPTH        = 64,
  parameter int AGE_W        = 7,
  parameter bit KEEP_MAX     = 1'b0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swmm_pkg::ctl_t                 ctl_i,
  input  logic        [AGE_W-1:0]        win_i,
  input  logic signed [SAMPLE_WIDTH-1:0] key_i,
  output logic signed [SAMPLE_WIDTH-1:0] head_d_o
);
  import swmm_pkg::*;

  logic                           kept_w  [0:DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] val_w   [0:DEPTH];
  logic        [AGE_W-1:0]        age_w   [0:DEPTH];
  logic        [DEPTH-1:0]        valid_w;
  logic signed [SAMPLE_WIDTH-1:0] vald_w  [0:DEPTH-1];
  logic                           shift;

  // head leaves once its age reaches the window after this item
  assign shift = valid_w[0] && (({1'b0, age_w[0]} + (AGE_W+1)'(1)) >= {1'b0, win_i});

  assign kept_w[DEPTH] = 1'b0;
  assign val_w[DEPTH]  = '0;
  assign age_w[DEPTH]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic kept_prev;
    if (i == 0) begin : g_head
      assign kept_prev = 1'b0;
    end else begin : g_body
      assign kept_prev = kept_w[i-1];
    end

    swmm_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .AGE_W       (AGE_W),
      .KEEP_MAX    (KEEP_MAX),
      .IS_HEAD     (i == 0)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl_i),
      .shift_i    (shift),
      .key_i      (key_i),
      .kept_prev_i(kept_prev),
      .kept_next_i(kept_w[i+1]),
      .nxt_val_i  (val_w[i+1]),
      .nxt_age_i  (age_w[i+1]),
      .kept_o     (kept_w[i]),
      .val_o      (val_w[i]),
      .age_o      (age_w[i]),
      .valid_o    (valid_w[i]),
      .val_d_o    (vald_w[i])
    );
  end

  assign head_d_o = vald_w[0];

  // occupied cells form one run from the head
  a_valid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_w >> 1) & ~valid_w) == '0)
    else $error("swmm_chain: gap in occupied cells");

  // head never outlives the window
  a_head_age: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_w[0] |-> (age_w[0] < win_i))
    else $error("swmm_chain: head entry older than window");

  // a flush leaves the queue empty
  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.flush |=> (valid_w == '0))
    else $error("swmm_chain: queue not empty after flush");

endmodule
